// ===== rtl/eabu_pkg.sv =====
// Package with opcodes, error codes and front-to-back queue types for the ALU and branch unit
`timescale 1ns / 1ps
`default_nettype none
package eabu_pkg;
    localparam logic [4:0] OP_MOV = 5'd0;
    localparam logic [4:0] OP_LEA = 5'd1;
    localparam logic [4:0] OP_XCHG = 5'd2;
    localparam logic [4:0] OP_CMP = 5'd3;
    localparam logic [4:0] OP_ADD = 5'd4;
    localparam logic [4:0] OP_SUB = 5'd5;
    localparam logic [4:0] OP_MUL = 5'd6;
    localparam logic [4:0] OP_DIV = 5'd7;
    localparam logic [4:0] OP_NEG = 5'd8;
    localparam logic [4:0] OP_INC = 5'd9;
    localparam logic [4:0] OP_DEC = 5'd10;
    localparam logic [4:0] OP_JMP = 5'd11;
    localparam logic [4:0] OP_JE = 5'd12;
    localparam logic [4:0] OP_JNE = 5'd13;
    localparam logic [4:0] OP_JG = 5'd14;
    localparam logic [4:0] OP_JGE = 5'd15;
    localparam logic [4:0] OP_JL = 5'd16;
    localparam logic [4:0] OP_JLE = 5'd17;
    localparam logic [4:0] OP_NOT = 5'd18;
    localparam logic [4:0] OP_AND = 5'd19;
    localparam logic [4:0] OP_OR = 5'd20;
    localparam logic [4:0] OP_XOR = 5'd21;
    localparam logic [4:0] OP_SHL = 5'd22;
    localparam logic [4:0] OP_SHR = 5'd23;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_DIVZERO = 2'd2;

    typedef struct packed {
        logic [4:0] opcode;
        logic       illegal;
        logic       cond;
    } eabu_class_t;
endpackage
`default_nettype wire

// ===== rtl/eabu_front.sv =====
// Front part: rights check, branch condition and a two-entry queue toward the back part
`timescale 1ns / 1ps
`default_nettype none
module eabu_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [4:0]            opcode,
    input  wire logic [DATA_WIDTH-1:0] in_a,
    input  wire logic [DATA_WIDTH-1:0] in_b,
    input  wire logic [DATA_WIDTH-1:0] in_addr,
    input  wire logic                  first_writable,
    input  wire logic                  first_readable,
    input  wire logic                  second_writable,
    input  wire logic                  second_readable,
    input  wire logic                  second_addressable,
    input  wire logic                  flag_zero,
    input  wire logic                  flag_sign,
    input  wire logic                  flag_overflow,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output eabu_pkg::eabu_class_t      out_cls,
    output logic [DATA_WIDTH-1:0]      out_a,
    output logic [DATA_WIDTH-1:0]      out_b,
    output logic [DATA_WIDTH-1:0]      out_addr
);
    localparam int W = DATA_WIDTH;

    logic                  ok;
    logic                  so;
    eabu_pkg::eabu_class_t cls;
    eabu_pkg::eabu_class_t cls_reg  [2];
    logic [W-1:0]          a_reg    [2];
    logic [W-1:0]          b_reg    [2];
    logic [W-1:0]          addr_reg [2];
    logic                  wptr_reg;
    logic                  rptr_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;

    assign so = (flag_sign == flag_overflow);

    always_comb begin
        cls.opcode = opcode;
        cls.cond   = 1'b0;
        unique case (opcode) inside
            eabu_pkg::OP_MOV, eabu_pkg::OP_ADD, eabu_pkg::OP_SUB, eabu_pkg::OP_MUL,
            eabu_pkg::OP_DIV, eabu_pkg::OP_AND, eabu_pkg::OP_OR, eabu_pkg::OP_XOR,
            eabu_pkg::OP_SHL, eabu_pkg::OP_SHR: ok = first_writable & second_readable;
            eabu_pkg::OP_LEA: ok = first_writable & second_addressable;
            eabu_pkg::OP_XCHG: ok = first_writable & second_writable;
            eabu_pkg::OP_NEG, eabu_pkg::OP_INC, eabu_pkg::OP_DEC,
            eabu_pkg::OP_NOT: ok = first_writable;
            eabu_pkg::OP_CMP, eabu_pkg::OP_JMP, eabu_pkg::OP_JE, eabu_pkg::OP_JNE,
            eabu_pkg::OP_JG, eabu_pkg::OP_JGE, eabu_pkg::OP_JL,
            eabu_pkg::OP_JLE: ok = first_readable;
            default: ok = 1'b1;
        endcase
        unique case (opcode)
            eabu_pkg::OP_JMP: cls.cond = 1'b1;
            eabu_pkg::OP_JE:  cls.cond = flag_zero;
            eabu_pkg::OP_JNE: cls.cond = ~flag_zero;
            eabu_pkg::OP_JG:  cls.cond = ~flag_zero & so;
            eabu_pkg::OP_JGE: cls.cond = flag_zero | so;
            eabu_pkg::OP_JL:  cls.cond = ~flag_zero & ~so;
            eabu_pkg::OP_JLE: cls.cond = flag_zero | ~so;
            default:          cls.cond = 1'b0;
        endcase
        cls.illegal = ~ok;
    end

    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cls   = cls_reg[rptr_reg];
    assign out_a     = a_reg[rptr_reg];
    assign out_b     = b_reg[rptr_reg];
    assign out_addr  = addr_reg[rptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cls_reg[wptr_reg]  <= cls;
            a_reg[wptr_reg]    <= in_a;
            b_reg[wptr_reg]    <= in_b;
            addr_reg[wptr_reg] <= in_addr;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/eabu_back.sv =====
// Back part: pipelined execute with multiplier and radix-2 divider stages
`timescale 1ns / 1ps
`default_nettype none
module eabu_back #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  eabu_pkg::eabu_class_t      in_cls,
    input  wire logic [DATA_WIDTH-1:0] in_a,
    input  wire logic [DATA_WIDTH-1:0] in_b,
    input  wire logic [DATA_WIDTH-1:0] in_addr,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DATA_WIDTH-1:0]      out_res0,
    output logic                       out_wr0,
    output logic [DATA_WIDTH-1:0]      out_res1,
    output logic                       out_wr1,
    output logic                       out_jump,
    output logic [DATA_WIDTH-1:0]      out_target,
    output logic [1:0]                 out_err
);
    localparam int W = DATA_WIDTH;
    localparam int NS = W + 1;

    // stage 0 captures operands and magnitudes; stages 1..W each do one divide step
    logic                  vld_reg  [NS];
    eabu_pkg::eabu_class_t cls_reg  [NS];
    logic [W-1:0]          a_reg    [NS];
    logic [W-1:0]          b_reg    [NS];
    logic [W-1:0]          r0_reg   [NS];
    logic [W-1:0]          quo_reg  [NS];
    logic [W-1:0]          rem_reg  [NS];
    logic [W-1:0]          den_reg  [NS];
    logic                  qneg_reg [NS];
    logic                  advance;
    logic [W-1:0]          res0_next;

    assign advance  = ~vld_reg[NS-1] | out_ready;
    assign in_ready = advance;

    always_comb begin
        logic [2*W-1:0] prod;
        prod = in_a * in_b;
        res0_next = '0;
        case (in_cls.opcode) inside
            eabu_pkg::OP_MOV, eabu_pkg::OP_XCHG: res0_next = in_b;
            eabu_pkg::OP_LEA: res0_next = in_addr;
            eabu_pkg::OP_ADD: res0_next = in_a + in_b;
            eabu_pkg::OP_SUB: res0_next = in_a - in_b;
            eabu_pkg::OP_MUL: res0_next = prod[W-1:0];
            eabu_pkg::OP_NEG: res0_next = '0 - in_a;
            eabu_pkg::OP_INC: res0_next = in_a + W'(1);
            eabu_pkg::OP_DEC: res0_next = in_a - W'(1);
            eabu_pkg::OP_NOT: res0_next = ~in_a;
            eabu_pkg::OP_AND: res0_next = in_a & in_b;
            eabu_pkg::OP_OR:  res0_next = in_a | in_b;
            eabu_pkg::OP_XOR: res0_next = in_a ^ in_b;
            eabu_pkg::OP_SHL: res0_next = (in_b >= W) ? '0 : (in_a << in_b);
            eabu_pkg::OP_SHR: res0_next = (in_b >= W) ? '0 : (in_a >> in_b);
            default: res0_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) vld_reg[i] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cls_reg[0]  <= in_cls;
            a_reg[0]    <= in_a;
            b_reg[0]    <= in_b;
            r0_reg[0]   <= res0_next;
            quo_reg[0]  <= in_a[W-1] ? ('0 - in_a) : in_a;
            rem_reg[0]  <= '0;
            den_reg[0]  <= in_b[W-1] ? ('0 - in_b) : in_b;
            qneg_reg[0] <= in_a[W-1] ^ in_b[W-1];
            for (int i = 1; i < NS; i++) begin
                logic [W:0] trial;
                logic [W:0] sh;
                sh    = {rem_reg[i-1], quo_reg[i-1][W-1]};
                trial = sh - {1'b0, den_reg[i-1]};
                cls_reg[i]  <= cls_reg[i-1];
                a_reg[i]    <= a_reg[i-1];
                b_reg[i]    <= b_reg[i-1];
                r0_reg[i]   <= r0_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                qneg_reg[i] <= qneg_reg[i-1];
                if (!trial[W]) begin
                    rem_reg[i] <= trial[W-1:0];
                    quo_reg[i] <= {quo_reg[i-1][W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= sh[W-1:0];
                    quo_reg[i] <= {quo_reg[i-1][W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        eabu_pkg::eabu_class_t c;
        logic [4:0] op;
        c = cls_reg[NS-1];
        op = c.opcode;
        out_valid  = vld_reg[NS-1];
        out_res0   = '0;
        out_wr0    = 1'b0;
        out_res1   = '0;
        out_wr1    = 1'b0;
        out_jump   = 1'b0;
        out_target = '0;
        out_err    = eabu_pkg::ERR_NONE;
        if (c.illegal) begin
            out_err = eabu_pkg::ERR_ILLEGAL;
        end else if (op == eabu_pkg::OP_DIV) begin
            if (b_reg[NS-1] == '0) begin
                out_err = eabu_pkg::ERR_DIVZERO;
            end else begin
                out_wr0  = 1'b1;
                out_res0 = qneg_reg[NS-1] ? ('0 - quo_reg[NS-1]) : quo_reg[NS-1];
            end
        end else if (op >= eabu_pkg::OP_JMP && op <= eabu_pkg::OP_JLE) begin
            out_jump   = c.cond;
            out_target = c.cond ? a_reg[NS-1] : '0;
        end else if (op <= eabu_pkg::OP_SHR && op != eabu_pkg::OP_CMP) begin
            out_wr0  = 1'b1;
            out_res0 = r0_reg[NS-1];
            if (op == eabu_pkg::OP_XCHG) begin
                out_wr1  = 1'b1;
                out_res1 = a_reg[NS-1];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/emulated_alu_and_branch_unit.sv =====
// Top level of the emulated ALU and branch unit
//
// Usage: one instruction per s_axis transfer, one result per m_axis transfer, in order.
// s_axis_tdata packs opcode, operand values, address, rights and flags.
// m_axis_tdata packs the write-backs, jump decision, target and error code.
// The front classifies each instruction and parks it in a two-entry queue; the
// back runs a DATA_WIDTH + 1 stage pipeline (one capture stage, then one divide
// step per stage) whose last stage is the output register.
// Path: an accepted instruction is written into the queue, then moves through stage 0
// to stage DATA_WIDTH; m_axis_tvalid is the valid bit of the last stage.
// Throughput: one transfer per cycle while m_axis_tready is high.
// When the receiver stalls, the back pipeline holds, the queue takes up to two
// more instructions, then s_axis_tready drops; s_axis_tready comes from a register.
// Reset (aresetn low, synchronous) empties the queue and the pipeline.
// Results that are not written read as zero, and the jump target is zero when
// no jump is taken.
//
`timescale 1ns / 1ps
`default_nettype none
module emulated_alu_and_branch_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[4:0], value_first[36:5], value_second[68:37], address_second[100:69],
    // first_writable[101], first_readable[102], second_writable[103],
    // second_readable[104], second_addressable[105], flag_zero[106],
    // flag_sign[107], flag_overflow[108], zero pad[111:109]
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_first[31:0], write_first[32], result_second[64:33], write_second[65],
    // jump_taken[66], jump_target[98:67], error_code[100:99], zero pad[103:101]
    output logic [103:0]      m_axis_tdata
);
    localparam int W = DATA_WIDTH;

    eabu_pkg::eabu_class_t cls;
    logic [W-1:0] a, b, addr, r0, r1, tgt;
    logic [W-1:0] q_a, q_b, q_addr;
    logic q_valid, q_ready;
    logic wr0, wr1, jmp;
    logic [1:0] err;

    assign a    = W'(s_axis_tdata[36:5]);
    assign b    = W'(s_axis_tdata[68:37]);
    assign addr = W'(s_axis_tdata[100:69]);

    eabu_front #(.DATA_WIDTH(W)) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .opcode            (s_axis_tdata[4:0]),
        .in_a              (a),
        .in_b              (b),
        .in_addr           (addr),
        .first_writable    (s_axis_tdata[101]),
        .first_readable    (s_axis_tdata[102]),
        .second_writable   (s_axis_tdata[103]),
        .second_readable   (s_axis_tdata[104]),
        .second_addressable(s_axis_tdata[105]),
        .flag_zero         (s_axis_tdata[106]),
        .flag_sign         (s_axis_tdata[107]),
        .flag_overflow     (s_axis_tdata[108]),
        .out_valid         (q_valid),
        .out_ready         (q_ready),
        .out_cls           (cls),
        .out_a             (q_a),
        .out_b             (q_b),
        .out_addr          (q_addr)
    );

    eabu_back #(.DATA_WIDTH(W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_cls    (cls),
        .in_a      (q_a),
        .in_b      (q_b),
        .in_addr   (q_addr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res0  (r0),
        .out_wr0   (wr0),
        .out_res1  (r1),
        .out_wr1   (wr1),
        .out_jump  (jmp),
        .out_target(tgt),
        .out_err   (err)
    );

    assign m_axis_tdata = {3'b000, err, 32'(tgt), jmp, wr1, 32'(r1), wr0, 32'(r0)};
endmodule
`default_nettype wire
